/* hdl/npp_pkg.sv */
package npp_pkg;

  // noise coordinate widths
  localparam int CoordW    = 10;
  localparam int StepW     = 17;
  localparam int CellIntW  = 19;
  localparam int FracW     = 8;
  localparam int DivSteps  = CellIntW + FracW;
  localparam int GridW     = 6;
  localparam int SineSumW  = 11;
  localparam int CfgIdxW   = 3;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW_PHASE     = 3'd0,
    REG_COL_PHASE     = 3'd1,
    REG_PALETTE_SHIFT = 3'd2,
    REG_U_STEP        = 3'd3,
    REG_V_STEP        = 3'd4,
    REG_INTENSITY     = 3'd5,
    REG_NOISE_SCALE   = 3'd6
  } cfg_reg_t;

  localparam logic [31:0] HashMulX   = 32'h27d4eb2d;
  localparam logic [31:0] HashMulY   = 32'h9e3779b1;
  localparam logic [31:0] HashMulMix = 32'h7feb352d;

  typedef logic [7:0] quarter_rom_t [65];
  localparam quarter_rom_t SINE_QUARTER = '{
    8'd0, 8'd3, 8'd6, 8'd9, 8'd12, 8'd15, 8'd18, 8'd21, 8'd24, 8'd28, 8'd31, 8'd34, 8'd37,
    8'd40, 8'd43, 8'd46, 8'd48, 8'd51, 8'd54, 8'd57, 8'd60, 8'd63, 8'd65, 8'd68, 8'd71,
    8'd73, 8'd76, 8'd78, 8'd81, 8'd83, 8'd85, 8'd88, 8'd90, 8'd92, 8'd94, 8'd96, 8'd98,
    8'd100, 8'd102, 8'd104, 8'd106, 8'd108, 8'd109, 8'd111, 8'd112, 8'd114, 8'd115,
    8'd117, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd124, 8'd125,
    8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127
  };

  typedef logic [23:0] grad_rom_t [256];

  // sine byte from the quarter wave
  function automatic logic [7:0] sine_byte(input logic [7:0] a);
    logic [6:0] q;
    logic [6:0] k;
    q = a[6:0];
    k = (q <= 7'd64) ? q : 7'(8'd128 - {1'b0, q});
    if (!a[7]) return 8'd128 + SINE_QUARTER[k];
    return (k == 7'd0) ? 8'd128 : 8'd127 - SINE_QUARTER[k];
  endfunction

  // one restoring division step: {quotient bit, remainder}
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic din,
                                          input logic [7:0] s);
    logic [8:0] t;
    t = {rem, din};
    if (t >= {1'b0, s}) return {1'b1, 8'(t - {1'b0, s})};
    return {1'b0, rem[6:0], din};
  endfunction

  // first half of the lattice hash
  function automatic logic [31:0] hash_pre(input logic [GridW-1:0] gx,
                                           input logic [GridW-1:0] gy);
    logic [31:0] h;
    h = (32'(gx) * HashMulX) ^ (32'(gy) * HashMulY);
    return h ^ (h >> 16);
  endfunction

  // gradient table, built at elaboration
  function automatic grad_rom_t build_grad();
    grad_rom_t rom;
    int r, g, b, d;
    for (int i = 0; i < 256; i++) begin
      if (i < 128) begin
        r = (80 * i) / 255;
        g = 200 - (220 * i + 254) / 255;
        b = 160 + (190 * i) / 255;
      end else begin
        d = 2 * i - 255;
        r = 40 + (140 * d) / 255;
        g = 90 - (30 * d + 254) / 255;
        b = 255 - (55 * d + 254) / 255;
      end
      rom[i] = {8'(r), 8'(g), 8'(b)};
    end
    return rom;
  endfunction

endpackage

/* hdl/npp_div.sv */
module npp_div (
  input  logic                                          clk,
  input  logic                                          adv,
  input  logic [npp_pkg::CellIntW-1:0]                  num,
  input  logic [7:0]                                    s,
  output logic [npp_pkg::DivSteps-1:0]                  quo
);
  import npp_pkg::*;

  logic [7:0]          rem [DivSteps];
  logic [DivSteps-1:0] dvd [DivSteps];
  logic [DivSteps-1:0] qs  [DivSteps];
  logic [8:0]          st  [DivSteps];

  // compare and subtract for every stage: {quotient bit, remainder}
  always_comb begin
    st[0] = div_step(8'd0, num[CellIntW-1], s);
    for (int k = 1; k < DivSteps; k++) begin
      st[k] = div_step(rem[k-1], dvd[k-1][DivSteps-1], s);
    end
  end

  // one quotient bit per stage, integer bits then fraction bits
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= st[0][7:0];
      qs[0]  <= {{(DivSteps-1){1'b0}}, st[0][8]};
      dvd[0] <= {num[CellIntW-2:0], {(FracW+1){1'b0}}};
      for (int k = 1; k < DivSteps; k++) begin
        rem[k] <= st[k][7:0];
        qs[k]  <= {qs[k-1][DivSteps-2:0], st[k][8]};
        dvd[k] <= {dvd[k-1][DivSteps-2:0], 1'b0};
      end
    end
  end

  assign quo = qs[DivSteps-1];

endmodule

/* hdl/noise_plasma_pixel_gen.sv */
// Aurora pixel generator. One pixel coordinate enters per clock while the output
// is not stalled; throughput is one pixel per clock, set by a fully pipelined
// datapath whose longest part is the bit-per-stage divider that splits each
// scaled coordinate into noise cell and fraction (27 stages). A stall on the
// output freezes the whole pipeline, so input stall follows output stall.
// Configuration registers must only be written while no pixel is in flight.
module noise_plasma_pixel_gen (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [npp_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [npp_pkg::StepW-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [npp_pkg::CoordW-1:0]        pix_x,
  input  logic [npp_pkg::CoordW-1:0]        pix_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  output logic [7:0]                        color_index
);
  import npp_pkg::*;

  localparam grad_rom_t GRAD = build_grad();

  logic [7:0]       row_phase, col_phase, palette_shift, intensity, noise_scale;
  logic [StepW-1:0] u_step, v_step;
  logic [7:0]       scale;
  logic             adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_phase     <= '0;
      col_phase     <= '0;
      palette_shift <= '0;
      u_step        <= StepW'(64);
      v_step        <= StepW'(64);
      intensity     <= 8'd255;
      noise_scale   <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_PHASE:     row_phase     <= cfg_data[7:0];
        REG_COL_PHASE:     col_phase     <= cfg_data[7:0];
        REG_PALETTE_SHIFT: palette_shift <= cfg_data[7:0];
        REG_U_STEP:        u_step        <= cfg_data;
        REG_V_STEP:        v_step        <= cfg_data;
        REG_INTENSITY:     intensity     <= cfg_data[7:0];
        REG_NOISE_SCALE:   noise_scale   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign scale    = (noise_scale == 8'd0) ? 8'd1 : noise_scale;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: scaled coordinates and sine bands
  logic                v1;
  logic [CellIntW-1:0] ui1, vi1;
  logic [SineSumW-1:0] sine1;
  logic [7:0]          ridx, cidx;
  logic [26:0]         umul, vmul;

  assign ridx = 8'(pix_y * 2'd3) + row_phase;
  assign cidx = 8'(pix_x * 3'd5) + col_phase;
  assign umul = 27'(pix_x) * 27'(u_step);
  assign vmul = 27'(pix_y) * 27'(v_step);

  always_ff @(posedge clk) begin
    if (adv) begin
      ui1   <= umul[26:8];
      vi1   <= vmul[26:8];
      sine1 <= SineSumW'(sine_byte(cidx)) * SineSumW'(3) +
               SineSumW'(sine_byte(ridx)) * SineSumW'(2);
    end
  end

  // cell and fraction dividers
  logic [DivSteps-1:0] qu, qv;

  npp_div u_div_u (.clk(clk), .adv(adv), .num(ui1), .s(scale), .quo(qu));
  npp_div u_div_v (.clk(clk), .adv(adv), .num(vi1), .s(scale), .quo(qv));

  logic [DivSteps-1:0] vd;
  logic [SineSumW-1:0] sd [DivSteps];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= sine1;
      for (int k = 1; k < DivSteps; k++) sd[k] <= sd[k-1];
    end
  end

  logic [GridW-1:0] x0, y0, x1, y1;
  logic [7:0]       fu, fv;

  assign x0 = qu[FracW+GridW-1:FracW];
  assign y0 = qv[FracW+GridW-1:FracW];
  assign x1 = x0 + 1'b1;
  assign y1 = y0 + 1'b1;
  assign fu = qu[FracW-1:0];
  assign fv = qv[FracW-1:0];

  // stage a: squares and first hash half
  logic [7:0]          fua, fva, t2u, t2v;
  logic [31:0]         ha [4];
  logic [SineSumW-1:0] sa;
  logic [15:0]         squ, sqv;

  assign squ = fu * fu;
  assign sqv = fv * fv;

  // stage b: smoothstep weights and hash multiply
  logic [7:0]          wub, wvb;
  logic [31:0]         hb [4];
  logic [SineSumW-1:0] sb;
  logic [15:0]         cuu, cuv;

  assign cuu = t2u * fua;
  assign cuv = t2v * fva;

  // stage c: lattice values
  logic [7:0]          lat [4];
  logic [7:0]          wuc, wvc;
  logic [SineSumW-1:0] sc;

  // stage d: horizontal lerps
  logic signed [9:0]   topd, botd;
  logic [7:0]          wvd;
  logic [SineSumW-1:0] sdd;
  logic signed [17:0]  pt, pb;

  assign pt = ({10'b0, lat[1]} - {10'b0, lat[0]}) * {10'b0, wuc};
  assign pb = ({10'b0, lat[3]} - {10'b0, lat[2]}) * {10'b0, wuc};

  // stage e: vertical lerp from top towards bottom
  logic [7:0]          ne;
  logic [SineSumW-1:0] se;
  logic signed [19:0]  pv;

  assign pv = ({{10{botd[9]}}, botd} - {{10{topd[9]}}, topd}) * {12'b0, wvd};

  // stage f: gain; stage g: palette offset
  logic [7:0]  valf, idxg;
  logic [12:0] sumf;
  logic [17:0] gprod;

  assign sumf  = 13'(se) + 13'(ne) * 13'd3;
  assign gprod = 18'(sumf) * 18'(intensity[7:3]);

  logic va, vb, vc, vdd, ve, vf, vg;

  always_ff @(posedge clk) begin
    if (adv) begin
      fua   <= fu;
      fva   <= fv;
      t2u   <= squ[15:8];
      t2v   <= sqv[15:8];
      ha[0] <= hash_pre(x0, y0);
      ha[1] <= hash_pre(x1, y0);
      ha[2] <= hash_pre(x0, y1);
      ha[3] <= hash_pre(x1, y1);
      sa    <= sd[DivSteps-1];

      wub <= 8'(t2u * 2'd3 - {cuu[15:8], 1'b0});
      wvb <= 8'(t2v * 2'd3 - {cuv[15:8], 1'b0});
      for (int i = 0; i < 4; i++) hb[i] <= ha[i] * HashMulMix;
      sb  <= sa;

      for (int i = 0; i < 4; i++) lat[i] <= 8'(hb[i] ^ (hb[i] >> 15));
      wuc <= wub;
      wvc <= wvb;
      sc  <= sb;

      topd <= $signed({2'b0, lat[0]}) + 10'(pt >>> 8);
      botd <= $signed({2'b0, lat[2]}) + 10'(pb >>> 8);
      wvd  <= wvc;
      sdd  <= sc;

      ne <= 8'(topd + 10'(pv >>> 8));
      se <= sdd;

      valf <= gprod[15:8];

      idxg <= valf + palette_shift;

      {red, green, blue} <= GRAD[idxg];
      color_index        <= idxg;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; vd <= '0; va <= 1'b0; vb <= 1'b0; vc <= 1'b0;
      vdd <= 1'b0; ve <= 1'b0; vf <= 1'b0; vg <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      vd        <= {vd[DivSteps-2:0], v1};
      va        <= vd[DivSteps-1];
      vb        <= va;
      vc        <= vb;
      vdd       <= vc;
      ve        <= vdd;
      vf        <= ve;
      vg        <= vf;
      out_valid <= vg;
    end
  end

  // the pipeline only holds when a finished colour is refused
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a refused output");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(color_index)))
    else $error("refused colour lost");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !vg) |=> !out_valid)
    else $error("colour repeated");

endmodule

/* sim/noise_plasma_pixel_gen_tb.sv */
`timescale 1ns / 100ps

module noise_plasma_pixel_gen_tb;
  import npp_pkg::*;

  localparam int Latency = 35;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [StepW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CoordW-1:0] pix_x = '0;
  logic [CoordW-1:0] pix_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red, green, blue, color_index;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] idx;
  } colour_t;

  colour_t colour_q[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // own copy of the registers
  logic [7:0] m_row_phase, m_col_phase, m_palette_shift, m_intensity, m_noise_scale;
  logic [16:0] m_u_step, m_v_step;

  noise_plasma_pixel_gen uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .pix_x(pix_x), .pix_y(pix_y),
    .out_valid(out_valid), .out_stall(out_stall), .red(red), .green(green),
    .blue(blue), .color_index(color_index)
  );

  always #4 clk = ~clk;

  // sine band from the quarter wave table
  localparam logic [7:0] QuarterTab [65] = '{
    0, 3, 6, 9, 12, 15, 18, 21, 24, 28, 31, 34, 37, 40, 43, 46, 48,
    51, 54, 57, 60, 63, 65, 68, 71, 73, 76, 78, 81, 83, 85, 88, 90,
    92, 94, 96, 98, 100, 102, 104, 106, 108, 109, 111, 112, 114, 115, 117, 118,
    119, 120, 121, 122, 123, 124, 124, 125, 126, 126, 127, 127, 127, 127, 127, 127
  };

  function automatic int unsigned band(int unsigned a);
    int unsigned q, k;
    a = a & 255;
    q = a & 127;
    k = (q <= 64) ? q : 128 - q;
    if (a < 128) return 128 + QuarterTab[k];
    return (k == 0) ? 128 : 127 - QuarterTab[k];
  endfunction

  function automatic int lattice_val(bit [31:0] gx, bit [31:0] gy);
    bit [31:0] h;
    h = (gx * 32'h27d4eb2d) ^ (gy * 32'h9e3779b1);
    h = h ^ (h >> 16);
    h = h * 32'h7feb352d;
    h = h ^ (h >> 15);
    return int'(h & 255);
  endfunction

  function automatic int ease(int unsigned t);
    int unsigned t2, t3;
    t2 = (t * t) >> 8;
    t3 = (t2 * t) >> 8;
    return int'((3 * t2 - 2 * t3) & 255);
  endfunction

  // lerp with a floor shift (arithmetic shift floors)
  function automatic int blend(int a, int b, int w);
    return a + ((b - a) * w >>> 8);
  endfunction

  function automatic colour_t predict_colour(int unsigned x, int unsigned y);
    int unsigned s, ui, vi, x0, y0, x1, y1, n, gain, val, i, d;
    int wu, wv, top, bot;
    colour_t c;
    s = (m_noise_scale == 0) ? 1 : m_noise_scale;
    ui = (x * m_u_step) >> 8;
    vi = (y * m_v_step) >> 8;
    x0 = (ui / s) % 64;
    y0 = (vi / s) % 64;
    x1 = (x0 + 1) % 64;
    y1 = (y0 + 1) % 64;
    wu = ease(((ui % s) * 256) / s);
    wv = ease(((vi % s) * 256) / s);
    top = blend(lattice_val(x0, y0), lattice_val(x1, y0), wu);
    bot = blend(lattice_val(x0, y1), lattice_val(x1, y1), wu);
    n = blend(top, bot, wv) & 255;
    gain = (m_intensity * 32) >> 8;
    val = ((band(x * 5 + m_col_phase) * 3 + band(y * 3 + m_row_phase) * 2 + n * 3)
           * gain) >> 8;
    i = (val + m_palette_shift) & 255;
    if (i < 128) begin
      c.r = 8'((80 * i) / 255);
      c.g = 8'(200 - (220 * i + 254) / 255);
      c.b = 8'(160 + (190 * i) / 255);
    end else begin
      d = 2 * i - 255;
      c.r = 8'(40 + (140 * d) / 255);
      c.g = 8'(90 - (30 * d + 254) / 255);
      c.b = 8'(255 - (55 * d + 254) / 255);
    end
    c.idx = 8'(i);
    return c;
  endfunction

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= StepW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROW_PHASE:     m_row_phase = 8'(value);
      REG_COL_PHASE:     m_col_phase = 8'(value);
      REG_PALETTE_SHIFT: m_palette_shift = 8'(value);
      REG_U_STEP:        m_u_step = 17'(value);
      REG_V_STEP:        m_v_step = 17'(value);
      REG_INTENSITY:     m_intensity = 8'(value);
      REG_NOISE_SCALE:   m_noise_scale = 8'(value);
      default: ;
    endcase
  endtask

  // one pixel transfer; valid stays up between back-to-back pixels
  task automatic send_pixel(int unsigned x, int unsigned y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pix_x <= CoordW'(x);
    pix_y <= CoordW'(y);
    colour_q.push_back(predict_colour(x, y));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (colour_q.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    colour_t exp_c;
    if (!rst && out_valid && !out_stall) begin
      if (colour_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h %h %h idx %h",
                                       red, green, blue, color_index);
      end else begin
        exp_c = colour_q.pop_front();
        if (exp_c.r !== red || exp_c.g !== green || exp_c.b !== blue ||
            exp_c.idx !== color_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected %h %h %h idx %h, got %h %h %h idx %h",
                     exp_c.r, exp_c.g, exp_c.b, exp_c.idx, red, green, blue, color_index);
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(1023, 0);
    send_pixel(0, 1023);
    send_pixel(341, 682);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_ROW_PHASE, 255);
    write_reg(REG_COL_PHASE, 255);
    write_reg(REG_PALETTE_SHIFT, 255);
    write_reg(REG_U_STEP, 65536);
    write_reg(REG_V_STEP, 131071);
    write_reg(REG_INTENSITY, 255);
    write_reg(REG_NOISE_SCALE, 0);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(512, 3);
    drain();
    // large scale: smoothstep top end
    write_reg(REG_U_STEP, 255);
    write_reg(REG_V_STEP, 254);
    write_reg(REG_NOISE_SCALE, 255);
    write_reg(REG_INTENSITY, 0);
    send_pixel(255, 255);
    send_pixel(254, 1);
    drain();
    write_reg(REG_INTENSITY, 8);
    write_reg(REG_U_STEP, 0);
    write_reg(REG_V_STEP, 0);
    write_reg(REG_PALETTE_SHIFT, 0);
    send_pixel(1000, 999);
    send_pixel(7, 1022);
    drain();
    write_reg(cfg_reg_t'(3'd7), 12345);
    send_pixel(100, 200);
    drain();
  endtask

  task automatic random_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    write_reg(REG_ROW_PHASE, $urandom_range(255));
    write_reg(REG_COL_PHASE, $urandom_range(255));
    write_reg(REG_PALETTE_SHIFT, $urandom_range(255));
    write_reg(REG_U_STEP, ($urandom_range(3) == 0) ? $urandom_range(131071)
                                                 : $urandom_range(1024));
    write_reg(REG_V_STEP, ($urandom_range(3) == 0) ? $urandom_range(131071)
                                                 : $urandom_range(1024));
    write_reg(REG_INTENSITY, $urandom_range(255));
    write_reg(REG_NOISE_SCALE, ($urandom_range(4) == 0) ? 0 : $urandom_range(255));
    for (int k = 0; k < count; k++) send_pixel($urandom_range(1023), $urandom_range(1023));
    drain();
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 4; p++) begin
      random_phase(0, 0, 55);
      random_phase(58, 0, 55);
      random_phase(0, 58, 55);
      random_phase(36, 36, 55);
    end
    recv_stall_pct = 0;
  endtask

  initial begin
    m_row_phase = 0; m_col_phase = 0; m_palette_shift = 0;
    m_u_step = 64; m_v_step = 64; m_intensity = 255; m_noise_scale = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    if (mismatches == 0 && colour_q.size() == 0) begin
      $display("noise_plasma_pixel_gen_tb passed");
    end else begin
      $display("noise_plasma_pixel_gen_tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("noise_plasma_pixel_gen_tb failed");
    $finish;
  end

endmodule
